>>> hdl/wav_header_strip_parser_assert.svh
// Assertion macros shared by the WAV header parser modules.
`ifndef WAV_HEADER_STRIP_PARSER_ASSERT_SVH
`define WAV_HEADER_STRIP_PARSER_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define WAVP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the cycle after.
`define WAVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/wavp_pkg.sv
// Types and constants shared by the WAV header parser modules.
package wavp_pkg;

    // Input beat: one byte of the file and its end-of-file flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    // Output beat: one result item.
    typedef struct packed {
        logic [1:0]  out_kind;
        logic [31:0] out_sample;
        logic [2:0]  out_status;
        logic [15:0] fmt_type;
        logic [15:0] fmt_channels;
        logic [31:0] fmt_rate;
        logic [31:0] fmt_byte_rate;
        logic [15:0] fmt_align;
        logic [15:0] fmt_bits;
        logic        out_last;
    } out_t;

    // Queue entry: everything one input byte caused, at most two results.
    typedef struct packed {
        logic       has_main;
        logic       has_status;
        logic [2:0] status;
        out_t       main;
    } queue_entry_t;

    // Result kinds.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Final status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd2;
    localparam logic [2:0] ST_RIFX      = 3'd3;
    localparam logic [2:0] ST_BAD_WIDTH = 3'd4;

    // Chunk and form tags as read little-endian.
    localparam logic [31:0] TAG_RIFX = 32'h5846_4952;
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Length of the captured fmt body.
    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [3:0]  FMT_LAST_IDX = 4'd15;

endpackage

>>> hdl/wavp_front.sv
// Front end: parses the byte stream and queues the results of each byte.
`include "wav_header_strip_parser_assert.svh"

module wavp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wavp_pkg::in_t         in_data,
    output logic                  push,
    output wavp_pkg::queue_entry_t push_data,
    input  logic                  queue_full
);
    import wavp_pkg::*;

    typedef enum logic [8:0] {
        PH_RIFF_ID   = 9'b000000001,
        PH_RIFF_SIZE = 9'b000000010,
        PH_WAVE      = 9'b000000100,
        PH_HDR       = 9'b000001000,
        PH_FMT       = 9'b000010000,
        PH_SKIP      = 9'b000100000,
        PH_FACT      = 9'b001000000,
        PH_DATA      = 9'b010000000,
        PH_DONE      = 9'b100000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] ws_reg, ws_next;
    logic [31:0] tag_reg, tag_next;
    logic [63:0] fmt_lo_reg, fmt_lo_next;
    logic [63:0] fmt_hi_reg, fmt_hi_next;
    logic [31:0] len_reg, len_next;
    logic [1:0]  held_reg, held_next;
    logic [2:0]  fstat_reg, fstat_next;

    logic        fire;
    logic [7:0]  b;
    logic [31:0] ws_acc;
    logic [31:0] ws_data;
    logic [31:0] len_dec;
    logic [63:0] fmt_mask;
    logic [63:0] fmt_byte;
    logic [2:0]  samp_len;
    logic [2:0]  held_inc;
    logic        emit_main;
    out_t        main;
    logic [2:0]  end_status;

    assign fire     = in_valid && in_ready;
    assign in_ready = !queue_full;
    assign b        = in_data.in_byte;

    // Word assembly for tags and sizes, and for payload samples.
    assign ws_acc  = ((cnt_reg[1:0] == 2'd0) ? 32'd0 : ws_reg)
                     | (32'(b) << {cnt_reg[1:0], 3'b000});
    assign ws_data = ((held_reg == 2'd0) ? 32'd0 : ws_reg)
                     | (32'(b) << {held_reg, 3'b000});
    assign held_inc = {1'b0, held_reg} + 3'd1;

    // Byte lane of the fmt body store.
    assign fmt_mask = 64'hFF << {cnt_reg[2:0], 3'b000};
    assign fmt_byte = 64'(b) << {cnt_reg[2:0], 3'b000};

    assign len_dec = (len_reg != 32'd0) ? (len_reg - 32'd1) : 32'd0;

    // Sample length in bytes from the bits field, zero when unsupported.
    always_comb
    begin
        unique case (fmt_hi_reg[63:48])
            16'd8:   samp_len = 3'd1;
            16'd16:  samp_len = 3'd2;
            16'd32:  samp_len = 3'd4;
            default: samp_len = 3'd0;
        endcase
    end

    // Parser next-state logic.
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        ws_next     = ws_reg;
        tag_next    = tag_reg;
        fmt_lo_next = fmt_lo_reg;
        fmt_hi_next = fmt_hi_reg;
        len_next    = len_reg;
        held_next   = held_reg;
        fstat_next  = fstat_reg;
        emit_main   = 1'b0;
        main        = '0;
        end_status  = ST_TRUNCATED;

        if (fire)
        begin
            unique case (phase_reg)
                PH_RIFF_ID, PH_WAVE:
                begin
                    ws_next  = ws_acc;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd3)
                    begin
                        cnt_next = 4'd0;
                        if (phase_reg == PH_WAVE)
                        begin
                            if (ws_acc == TAG_WAVE)
                            begin
                                phase_next = PH_HDR;
                            end
                            else
                            begin
                                fstat_next = ST_NOT_RIFF;
                                phase_next = PH_DONE;
                            end
                        end
                        else if (ws_acc == TAG_RIFF)
                        begin
                            phase_next = PH_RIFF_SIZE;
                        end
                        else
                        begin
                            fstat_next = (ws_acc == TAG_RIFX) ? ST_RIFX : ST_NOT_RIFF;
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_RIFF_SIZE, PH_FACT:
                begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd3)
                    begin
                        cnt_next   = 4'd0;
                        phase_next = (phase_reg == PH_RIFF_SIZE) ? PH_WAVE : PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    ws_next  = ws_acc;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd3)
                    begin
                        tag_next = ws_acc;
                    end
                    else if (cnt_reg == 4'd7)
                    begin
                        cnt_next = 4'd0;
                        len_next = ws_acc;
                        if (tag_reg == TAG_FMT)
                        begin
                            phase_next = PH_FMT;
                        end
                        else if (tag_reg == TAG_FACT)
                        begin
                            phase_next = PH_FACT;
                        end
                        else if (tag_reg == TAG_DATA)
                        begin
                            // Report the format once at the data header.
                            emit_main          = 1'b1;
                            main.out_kind      = KIND_FORMAT;
                            main.fmt_type      = fmt_lo_reg[15:0];
                            main.fmt_channels  = fmt_lo_reg[31:16];
                            main.fmt_rate      = fmt_lo_reg[63:32];
                            main.fmt_byte_rate = fmt_hi_reg[31:0];
                            main.fmt_align     = fmt_hi_reg[47:32];
                            main.fmt_bits      = fmt_hi_reg[63:48];
                            held_next          = 2'd0;
                            ws_next            = 32'd0;
                            if (samp_len != 3'd0)
                            begin
                                phase_next = PH_DATA;
                            end
                            else
                            begin
                                fstat_next = ST_BAD_WIDTH;
                                phase_next = PH_DONE;
                            end
                        end
                        else
                        begin
                            // A negative size counts as zero.
                            if (ws_acc[31] || (ws_acc == 32'd0))
                            begin
                                len_next   = 32'd0;
                                phase_next = PH_HDR;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_FMT:
                begin
                    if (!cnt_reg[3])
                    begin
                        fmt_lo_next = (fmt_lo_reg & ~fmt_mask) | fmt_byte;
                    end
                    else
                    begin
                        fmt_hi_next = (fmt_hi_reg & ~fmt_mask) | fmt_byte;
                    end
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == FMT_LAST_IDX)
                    begin
                        cnt_next = 4'd0;
                        if (!len_reg[31] && (len_reg > FMT_BODY_LEN))
                        begin
                            len_next   = len_reg - FMT_BODY_LEN;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            phase_next = PH_HDR;
                        end
                    end
                end
                PH_SKIP:
                begin
                    len_next = len_dec;
                    if (len_dec == 32'd0)
                    begin
                        cnt_next   = 4'd0;
                        phase_next = PH_HDR;
                    end
                end
                PH_DATA:
                begin
                    ws_next = ws_data;
                    if (held_inc >= samp_len)
                    begin
                        emit_main       = 1'b1;
                        main.out_kind   = KIND_SAMPLE;
                        main.out_sample = ws_data;
                        held_next       = 2'd0;
                    end
                    else
                    begin
                        held_next = held_inc[1:0];
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase

            // End of file: pick the status, then return to the reset state.
            if (in_data.in_last)
            begin
                if (phase_next == PH_DATA)
                begin
                    end_status = ST_OK;
                end
                else if (phase_next == PH_DONE)
                begin
                    end_status = fstat_next;
                end
                else
                begin
                    end_status = ST_TRUNCATED;
                end
                phase_next  = PH_RIFF_ID;
                cnt_next    = 4'd0;
                ws_next     = 32'd0;
                tag_next    = 32'd0;
                fmt_lo_next = 64'd0;
                fmt_hi_next = 64'd0;
                len_next    = 32'd0;
                held_next   = 2'd0;
                fstat_next  = ST_OK;
            end
        end
    end

    // Queue write.
    assign push                 = fire && (emit_main || in_data.in_last);
    assign push_data.has_main   = emit_main;
    assign push_data.has_status = in_data.in_last;
    assign push_data.status     = end_status;
    assign push_data.main       = main;

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF_ID;
            cnt_reg    <= 4'd0;
            ws_reg     <= 32'd0;
            tag_reg    <= 32'd0;
            fmt_lo_reg <= 64'd0;
            fmt_hi_reg <= 64'd0;
            len_reg    <= 32'd0;
            held_reg   <= 2'd0;
            fstat_reg  <= ST_OK;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            ws_reg     <= ws_next;
            tag_reg    <= tag_next;
            fmt_lo_reg <= fmt_lo_next;
            fmt_hi_reg <= fmt_hi_next;
            len_reg    <= len_next;
            held_reg   <= held_next;
            fstat_reg  <= fstat_next;
        end
    end

    // The data phase is only entered with a supported sample width.
    `WAVP_ASSERT_IMPLY(a_data_width, clk, rst_n, (phase_reg == PH_DATA), (samp_len != 3'd0), "data phase with unsupported sample width")

endmodule

>>> hdl/wavp_fifo.sv
// Short queue between the parser front end and the result back end.
`include "wav_header_strip_parser_assert.svh"

module wavp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  wavp_pkg::queue_entry_t push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output wavp_pkg::queue_entry_t head
);
    import wavp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    queue_entry_t    mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : (wr_ptr_reg + PW'(1));
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : (rd_ptr_reg + PW'(1));
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `WAVP_ASSERT_IMPLY(a_no_overflow, clk, rst_n, (count_reg == CW'(DEPTH)), !push, "push into a full queue")
    `WAVP_ASSERT_IMPLY(a_no_underflow, clk, rst_n, (count_reg == '0), !pop, "pop from an empty queue")

endmodule

>>> hdl/wavp_back.sv
// Back end: turns queue entries into result beats through an output register.
`include "wav_header_strip_parser_assert.svh"

module wavp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  wavp_pkg::queue_entry_t head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output wavp_pkg::out_t         out_data
);
    import wavp_pkg::*;

    logic ov_reg, ov_next;
    logic sent_reg, sent_next;
    out_t od_reg, od_next;
    logic load;

    assign load      = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // Load the next result: the main result first, then the status if any.
    always_comb
    begin
        pop       = 1'b0;
        ov_next   = ov_reg;
        sent_next = sent_reg;
        od_next   = od_reg;
        if (load)
        begin
            if (head_valid)
            begin
                ov_next = 1'b1;
                if (head.has_main && !sent_reg)
                begin
                    od_next          = head.main;
                    od_next.out_last = !head.has_status;
                    if (head.has_status)
                    begin
                        sent_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    od_next            = '0;
                    od_next.out_kind   = KIND_STATUS;
                    od_next.out_status = head.status;
                    od_next.out_last   = 1'b1;
                    pop                = 1'b1;
                    sent_next          = 1'b0;
                end
            end
            else
            begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            sent_reg <= 1'b0;
        end
        else
        begin
            ov_reg   <= ov_next;
            sent_reg <= sent_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

    // A half-sent entry stays at the head until its status goes out.
    `WAVP_ASSERT_IMPLY(a_half_sent, clk, rst_n, sent_reg, (head_valid && head.has_main && head.has_status), "half-sent entry left the queue head")

endmodule

>>> hdl/wav_header_strip_parser.sv
// Top level of the RIFF/WAVE byte-stream parser.
//
// Usage: the input channel (in_valid, in_ready, in_data) takes one byte of a
// WAV file per beat, with in_last set on the final byte. The output channel
// (out_valid, out_ready, out_data) delivers result beats: payload samples,
// one format report at the data chunk header, and a status at end of file.
// out_last marks the last result caused by one input byte.
// Throughput is one byte per cycle while the queue is not full; a byte that
// causes two results (a sample or format report plus the status) fills the
// output register twice, once per result. An accepted byte is parsed and
// queued, then its first result is loaded into the output register.
// The parser front end and the result back end are split by a queue of
// QUEUE_DEPTH entries; input is stalled only while that queue is full, so a
// stalled receiver backs up the queue before in_ready drops.
// Reset clears the parser to expect a new file, empties the queue and drops
// any pending result. After each final byte the parser returns to the same
// state by itself, ready for the next file.
module wav_header_strip_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  wavp_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output wavp_pkg::out_t out_data
);
    import wavp_pkg::*;

    logic         push;
    queue_entry_t push_data;
    logic         queue_full;
    logic         pop;
    logic         head_valid;
    queue_entry_t head;

    // Byte parser.
    wavp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // Result queue.
    wavp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Result sequencer and output register.
    wavp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

>>> tb/wav_header_strip_parser_tb.sv
// Self-checking testbench for the WAV header parser: directed and random files, stalls on both sides.
module wav_header_strip_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wavp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_BYTES = 400;

    // Common chunk tags used in the stimulus besides the package ones.
    localparam logic [31:0] TAG_LIST = 32'h5453_494c;
    localparam logic [31:0] TAG_JUNK = 32'h6b6e_756a;
    localparam logic [31:0] TAG_AVI  = 32'h2049_5641;

    // Parser phases of the predictor.
    typedef enum logic [8:0] {
        WP_RIFF_TAG  = 9'b000000001,
        WP_RIFF_SIZE = 9'b000000010,
        WP_FORM      = 9'b000000100,
        WP_CHUNK_HDR = 9'b000001000,
        WP_FMT_BODY  = 9'b000010000,
        WP_SKIP      = 9'b000100000,
        WP_FACT_BODY = 9'b001000000,
        WP_DATA      = 9'b010000000,
        WP_DONE      = 9'b100000000
    } wav_phase_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;

    int error_count  = 0;
    int results_seen = 0;
    int bytes_sent   = 0;
    int cycle_count  = 0;

    // Bytes of the file under construction.
    logic [7:0] file_bytes[$];

    // Results still to come out of the block, oldest first.
    out_t pending_results[$];

    // Predictor state.
    wav_phase_t  parse_phase;
    logic [31:0] hdr_count;
    logic [31:0] word_acc;
    logic [31:0] chunk_id;
    logic [31:0] chunk_left;
    logic [63:0] fmt_lo;
    logic [63:0] fmt_hi;
    logic [1:0]  sample_fill;
    logic [2:0]  end_status;

    wav_header_strip_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    // Back to the state that expects the first byte of a new file.
    function automatic void clear_parser();
        parse_phase = WP_RIFF_TAG;
        hdr_count   = '0;
        word_acc    = '0;
        chunk_id    = '0;
        chunk_left  = '0;
        fmt_lo      = '0;
        fmt_hi      = '0;
        sample_fill = '0;
        end_status  = '0;
    endfunction

    function automatic int unsigned sample_bytes(input logic [15:0] bits);
        case (bits)
            16'd8:   return 1;
            16'd16:  return 2;
            16'd32:  return 4;
            default: return 0;
        endcase
    endfunction

    // Advance the parser by one byte and queue the results it causes.
    function automatic void parse_wav_byte(input in_t beat);
        out_t        caused[$];
        out_t        res;
        logic [31:0] b;
        logic [4:0]  shift;
        int unsigned held;
        int unsigned width;

        b     = {24'd0, beat.in_byte};
        shift = {hdr_count[1:0], 3'b000};
        case (parse_phase)
            WP_RIFF_TAG, WP_FORM:
            begin
                word_acc = ((hdr_count == 0) ? 32'd0 : word_acc) | (b << shift);
                hdr_count++;
                if (hdr_count == 4)
                begin
                    hdr_count = 0;
                    if (parse_phase == WP_FORM)
                    begin
                        if (word_acc == TAG_WAVE)
                            parse_phase = WP_CHUNK_HDR;
                        else
                        begin
                            end_status  = ST_NOT_RIFF;
                            parse_phase = WP_DONE;
                        end
                    end
                    else if (word_acc == TAG_RIFF)
                        parse_phase = WP_RIFF_SIZE;
                    else
                    begin
                        end_status  = (word_acc == TAG_RIFX) ? ST_RIFX : ST_NOT_RIFF;
                        parse_phase = WP_DONE;
                    end
                end
            end
            WP_RIFF_SIZE, WP_FACT_BODY:
            begin
                hdr_count++;
                if (hdr_count == 4)
                begin
                    hdr_count   = 0;
                    parse_phase = (parse_phase == WP_RIFF_SIZE) ? WP_FORM : WP_CHUNK_HDR;
                end
            end
            WP_CHUNK_HDR:
            begin
                word_acc = ((hdr_count[1:0] == 2'd0) ? 32'd0 : word_acc) | (b << shift);
                hdr_count++;
                if (hdr_count == 4)
                    chunk_id = word_acc;
                else if (hdr_count == 8)
                begin
                    hdr_count  = 0;
                    chunk_left = word_acc;
                    if (chunk_id == TAG_FMT)
                        parse_phase = WP_FMT_BODY;
                    else if (chunk_id == TAG_FACT)
                        parse_phase = WP_FACT_BODY;
                    else if (chunk_id == TAG_DATA)
                    begin
                        // Data header done: report the format captured so far.
                        res               = '0;
                        res.out_kind      = KIND_FORMAT;
                        res.fmt_type      = fmt_lo[15:0];
                        res.fmt_channels  = fmt_lo[31:16];
                        res.fmt_rate      = fmt_lo[63:32];
                        res.fmt_byte_rate = fmt_hi[31:0];
                        res.fmt_align     = fmt_hi[47:32];
                        res.fmt_bits      = fmt_hi[63:48];
                        caused.push_back(res);
                        sample_fill = '0;
                        word_acc    = '0;
                        if (sample_bytes(fmt_hi[63:48]) != 0)
                            parse_phase = WP_DATA;
                        else
                        begin
                            end_status  = ST_BAD_WIDTH;
                            parse_phase = WP_DONE;
                        end
                    end
                    else
                    begin
                        // A negative size is taken as an empty chunk.
                        if (chunk_left[31])
                            chunk_left = '0;
                        parse_phase = (chunk_left == 0) ? WP_CHUNK_HDR : WP_SKIP;
                    end
                end
            end
            WP_FMT_BODY:
            begin
                if (hdr_count < 8)
                    fmt_lo[{hdr_count[2:0], 3'b000} +: 8] = beat.in_byte;
                else
                    fmt_hi[{hdr_count[2:0], 3'b000} +: 8] = beat.in_byte;
                hdr_count++;
                if (hdr_count == FMT_BODY_LEN)
                begin
                    hdr_count = 0;
                    if (!chunk_left[31] && chunk_left > FMT_BODY_LEN)
                    begin
                        chunk_left  = chunk_left - FMT_BODY_LEN;
                        parse_phase = WP_SKIP;
                    end
                    else
                        parse_phase = WP_CHUNK_HDR;
                end
            end
            WP_SKIP:
            begin
                if (chunk_left != 0)
                    chunk_left--;
                if (chunk_left == 0)
                begin
                    hdr_count   = 0;
                    parse_phase = WP_CHUNK_HDR;
                end
            end
            WP_DATA:
            begin
                held     = sample_fill;
                width    = sample_bytes(fmt_hi[63:48]);
                word_acc = ((held == 0) ? 32'd0 : word_acc) | (b << (held * 8));
                if (held + 1 >= width)
                begin
                    res            = '0;
                    res.out_kind   = KIND_SAMPLE;
                    res.out_sample = word_acc;
                    caused.push_back(res);
                    sample_fill = '0;
                end
                else
                    sample_fill = 2'(held + 1);
            end
            default:
            begin
            end
        endcase

        // The final byte of a file always adds a status result.
        if (beat.in_last)
        begin
            res          = '0;
            res.out_kind = KIND_STATUS;
            if (parse_phase == WP_DATA)
                res.out_status = ST_OK;
            else if (parse_phase == WP_DONE)
                res.out_status = end_status;
            else
                res.out_status = ST_TRUNCATED;
            caused.push_back(res);
            clear_parser();
        end

        if (caused.size() != 0)
        begin
            res          = caused.pop_back();
            res.out_last = 1'b1;
            caused.push_back(res);
        end
        foreach (caused[i])
            pending_results.push_back(caused[i]);
    endfunction

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected (kind %0d)",
                                          results_seen, out_data.out_kind));
            else
            begin
                want = pending_results.pop_front();
                check_field("out_kind", out_data.out_kind, want.out_kind);
                check_field("out_sample", out_data.out_sample, want.out_sample);
                check_field("out_status", out_data.out_status, want.out_status);
                check_field("fmt_type", out_data.fmt_type, want.fmt_type);
                check_field("fmt_channels", out_data.fmt_channels, want.fmt_channels);
                check_field("fmt_rate", out_data.fmt_rate, want.fmt_rate);
                check_field("fmt_byte_rate", out_data.fmt_byte_rate, want.fmt_byte_rate);
                check_field("fmt_align", out_data.fmt_align, want.fmt_align);
                check_field("fmt_bits", out_data.fmt_bits, want.fmt_bits);
                check_field("out_last", out_data.out_last, want.out_last);
            end
        end
    end

    // Receiver: stall a random number of cycles before taking each beat.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            int stall;
            stall = sink_idle_en ? $urandom_range(0, 13) : 0;
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Send one byte after a random gap and predict its results once accepted.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int  gap;
        in_t beat;
        gap           = src_idle_en ? $urandom_range(0, 13) : 0;
        beat.in_byte  = value;
        beat.in_last  = is_last;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        parse_wav_byte(beat);
        bytes_sent++;
    endtask

    task automatic send_file();
        int n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(file_bytes[i], i == n - 1);
        file_bytes.delete();
    endtask

    // File builders, all little-endian.
    function automatic void put_le(input logic [31:0] value, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(value[8 * i +: 8]);
    endfunction

    function automatic void put_noise(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_chunk(input logic [31:0] tag, input logic [31:0] chunk_size);
        put_le(tag, 4);
        put_le(chunk_size, 4);
    endfunction

    function automatic void put_riff_head();
        put_chunk(TAG_RIFF, $urandom);
        put_le(TAG_WAVE, 4);
    endfunction

    function automatic void put_fmt(input logic [31:0] fmt_size, input logic [15:0] code,
                                    input logic [15:0] chans, input logic [31:0] rate,
                                    input logic [31:0] brate, input logic [15:0] align,
                                    input logic [15:0] bits);
        put_chunk(TAG_FMT, fmt_size);
        put_le(code, 2);
        put_le(chans, 2);
        put_le(rate, 4);
        put_le(brate, 4);
        put_le(align, 2);
        put_le(bits, 2);
        if (!fmt_size[31] && fmt_size > FMT_BODY_LEN)
            put_noise(fmt_size - FMT_BODY_LEN);
    endfunction

    function automatic void put_random_fmt();
        logic [31:0] fmt_size;
        logic [15:0] bits;
        case ($urandom_range(0, 5))
            0:       fmt_size = $urandom_range(0, 15);
            1:       fmt_size = $urandom_range(17, 22);
            2:       fmt_size = {1'b1, 31'($urandom)};
            default: fmt_size = FMT_BODY_LEN;
        endcase
        case ($urandom_range(0, 7))
            0, 1:    bits = 16'd8;
            2, 3:    bits = 16'd16;
            4, 5:    bits = 16'd32;
            6:       bits = 16'd24;
            default: bits = 16'($urandom);
        endcase
        put_fmt(fmt_size, 16'($urandom), 16'($urandom), $urandom, $urandom,
                16'($urandom), bits);
    endfunction

    // Mostly well-formed file with random chunks; now and then corrupted or cut short.
    function automatic void put_random_wav();
        int          cut;
        logic [31:0] skip_len;
        put_riff_head();
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    skip_len = $urandom_range(0, 9);
                    put_chunk($urandom, skip_len);
                    put_noise(skip_len);
                end
                1:
                    put_chunk($urandom, {1'b1, 31'($urandom)});
                2:
                begin
                    put_chunk(TAG_FACT, $urandom_range(0, 12));
                    put_noise(4);
                end
                default:
                    put_random_fmt();
            endcase
        end
        if ($urandom_range(0, 7) != 0)
            put_random_fmt();
        put_chunk(TAG_DATA, $urandom);
        put_noise($urandom_range(0, 24));
        if ($urandom_range(0, 9) == 0)
            file_bytes[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
    endfunction

    // Well-formed files at each supported sample width.
    task automatic test_plain_pcm();
        // 16-bit stereo; the final byte completes a sample, so it also carries the status.
        put_riff_head();
        put_fmt(32'd16, 16'd1, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
        put_chunk(TAG_DATA, 32'd8);
        put_le(32'h8000_7fff, 4);
        put_le(32'hffff_0000, 4);
        send_file();
        // 8-bit with every other fmt field at its maximum.
        put_riff_head();
        put_fmt(32'd16, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'd8);
        put_chunk(TAG_DATA, 32'hffff_ffff);
        put_le(32'h0080_00ff, 3);
        send_file();
        // 32-bit with zero fields; the trailing partial sample is dropped.
        put_riff_head();
        put_fmt(32'd16, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 16'd32);
        put_chunk(TAG_DATA, 32'd0);
        put_le(32'hffff_ffff, 4);
        put_le(32'h0000_0000, 4);
        put_le(32'h0000_005a, 1);
        send_file();
    endtask

    // Files rejected at the RIFF tag or the form type.
    task automatic test_bad_headers();
        // RIFX is recognized and refused; the rest is ignored.
        put_chunk(TAG_RIFX, 32'd36);
        put_le(TAG_WAVE, 4);
        put_fmt(32'd16, 16'd1, 16'd1, 32'd8000, 32'd16000, 16'd2, 16'd16);
        send_file();
        // Some other leading tag.
        put_le(32'h0000_0000, 4);
        put_noise(6);
        send_file();
        // One bit off RIFF, ending right on the tag.
        put_le(TAG_RIFF ^ 32'h0100_0000, 4);
        send_file();
        // Correct RIFF tag but the form type is not WAVE.
        put_chunk(TAG_RIFF, $urandom);
        put_le(TAG_AVI, 4);
        put_noise(5);
        send_file();
        // A one-byte file ends inside the RIFF tag.
        put_le(32'h52, 1);
        send_file();
    endtask

    // Chunk walking: odd and negative sizes, fact, short, long and repeated fmt.
    task automatic test_chunk_walk();
        put_riff_head();
        put_chunk(TAG_LIST, 32'd5);
        put_noise(5);
        put_chunk(TAG_JUNK, 32'h8000_0010);
        put_chunk(TAG_FACT, 32'd4);
        put_noise(4);
        put_chunk(TAG_FACT, 32'd12);
        put_noise(4);
        put_fmt(32'd10, 16'd1, 16'd1, 32'd11025, 32'd11025, 16'd1, 16'd8);
        put_fmt(32'd20, 16'd1, 16'd2, 32'd96000, 32'd768000, 16'd8, 16'd32);
        put_fmt(32'hffff_fff0, 16'd3, 16'd1, 32'd8000, 32'd16000, 16'd2, 16'd16);
        put_chunk(TAG_DATA, 32'd6);
        put_noise(6);
        send_file();
    endtask

    // Files that end early or carry an unsupported sample width.
    task automatic test_endings();
        // Ends exactly at a chunk boundary, after the fmt body.
        put_riff_head();
        put_fmt(32'd16, 16'd1, 16'd1, 32'd22050, 32'd44100, 16'd2, 16'd16);
        send_file();
        // Ends partway through a chunk header.
        put_riff_head();
        put_le(TAG_DATA, 3);
        send_file();
        // Ends inside a skipped chunk.
        put_riff_head();
        put_chunk(TAG_LIST, 32'd100);
        put_noise(10);
        send_file();
        // Data with no fmt before it: a format of zeros, then a bad width.
        put_riff_head();
        put_chunk(TAG_DATA, 32'd4);
        put_noise(4);
        send_file();
        // 24-bit samples are not supported.
        put_riff_head();
        put_fmt(32'd16, 16'd1, 16'd2, 32'd48000, 32'd288000, 16'd6, 16'd24);
        put_chunk(TAG_DATA, 32'd6);
        put_noise(6);
        send_file();
        // The data header's last byte ends the file: format report and status together.
        put_riff_head();
        put_fmt(32'd16, 16'd1, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8);
        put_chunk(TAG_DATA, 32'd0);
        send_file();
        // Same, with a width that is refused.
        put_riff_head();
        put_fmt(32'd16, 16'd1, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd12);
        put_chunk(TAG_DATA, 32'd0);
        send_file();
    endtask

    // Random files, mostly well formed, with short noise files mixed in.
    task automatic test_random_files();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                put_noise($urandom_range(1, 12));
            else
                put_random_wav();
            send_file();
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        clear_parser();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_plain_pcm();
        test_bad_headers();
        test_chunk_walk();
        test_endings();
        test_random_files();

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain the outstanding results, then watch for strays.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
